// ===== hdl/acp_pkg.sv =====
package acp_pkg;

	localparam int COEF_W           = 24;
	localparam int COEF_FRAC_BITS   = 16;
	localparam int SUM_W            = 44;
	localparam int LANES            = 4;
	localparam int COLOUR_LANES     = 3;
	localparam int PIPE_STAGES      = 7;
	localparam int CFG_INDEX_W      = 3;
	localparam logic [15:0] RECIP_255 = 16'd32897;

	typedef enum logic [1:0] {
		REQ_PIXEL    = 2'd0,
		REQ_LIN_WR   = 2'd1,
		REQ_SRGB_WR  = 2'd2
	} req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_K1         = 3'd0,
		REG_K2         = 3'd1,
		REG_K3         = 3'd2,
		REG_K4         = 3'd3,
		REG_USE_LINEAR = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] k1;
		logic signed [COEF_W-1:0] k2;
		logic signed [COEF_W-1:0] k3;
		logic signed [SUM_W-1:0]  k4_term;
		logic                     use_linear;
	} coef_t;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] ld;
		logic                   lin_we;
		logic [7:0]             lin_idx;
		logic [7:0]             lin_val;
		logic                   srgb_we;
		logic [7:0]             srgb_idx;
		logic [7:0]             srgb_val;
	} pipe_ctl_t;

endpackage

// ===== hdl/acp_cfg.sv =====
module acp_cfg #(
	parameter int COEF_FRAC_BITS = acp_pkg::COEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [acp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [acp_pkg::COEF_W-1:0]         cfg_data,
	output acp_pkg::coef_t                     coef
);

	localparam int SW = acp_pkg::SUM_W;
	localparam logic signed [SW-1:0] HALF = SW'(64'd255 << (COEF_FRAC_BITS - 1));

	logic signed [acp_pkg::COEF_W-1:0] k1_q, k2_q, k3_q, k4_q;
	logic                              lin_q;
	logic signed [SW-1:0]              k4_term_q;
	logic signed [SW-1:0]              k4x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q  <= '0;
			k2_q  <= '0;
			k3_q  <= '0;
			k4_q  <= '0;
			lin_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				acp_pkg::REG_K1:         k1_q  <= cfg_data;
				acp_pkg::REG_K2:         k2_q  <= cfg_data;
				acp_pkg::REG_K3:         k3_q  <= cfg_data;
				acp_pkg::REG_K4:         k4_q  <= cfg_data;
				acp_pkg::REG_USE_LINEAR: lin_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// 65025 = 65536 - 512 + 1
	assign k4x = {{(SW-acp_pkg::COEF_W){k4_q[acp_pkg::COEF_W-1]}}, k4_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k4_term_q <= HALF;
		end else begin
			k4_term_q <= (k4x <<< 16) - (k4x <<< 9) + k4x + HALF;
		end
	end

	assign coef.k1         = k1_q;
	assign coef.k2         = k2_q;
	assign coef.k3         = k3_q;
	assign coef.k4_term    = k4_term_q;
	assign coef.use_linear = lin_q;

endmodule

// ===== hdl/acp_lane.sv =====
module acp_lane #(
	parameter int COEF_FRAC_BITS = acp_pkg::COEF_FRAC_BITS,
	parameter bit HAS_TABLES     = 1'b1
) (
	input  logic                 clk,
	input  acp_pkg::pipe_ctl_t   ctl,
	input  acp_pkg::coef_t       coef,
	input  logic [7:0]           a,
	input  logic [7:0]           b,
	output logic [7:0]           q
);

	localparam int SW = acp_pkg::SUM_W;
	localparam logic signed [SW-1:0] SAT_LIM = SW'(64'd65280 << COEF_FRAC_BITS);

	logic [7:0]        a_s1, b_s1;
	logic [7:0]        opa, opb;
	logic [15:0]       ab_s2;
	logic signed [32:0] k2a_s2, k3b_s2;
	logic signed [40:0] p1_s3;
	logic signed [33:0] sum_s3;
	logic signed [SW-1:0] t_s4, u_s4, sumx, n;
	logic              neg_s5, sat_s5;
	logic [15:0]       m_s5;
	logic [31:0]       prod;
	logic [7:0]        q_s6, q_s7;

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			a_s1 <= a;
			b_s1 <= b;
		end
	end

	generate
		if (HAS_TABLES) begin : g_tables
			logic [7:0] lin_mem  [256];
			logic [7:0] srgb_mem [256];
			logic [7:0] lin_a_s1, lin_b_s1, srgb_s7;

			always_ff @(posedge clk) begin
				if (ctl.lin_we) begin
					lin_mem[ctl.lin_idx] <= ctl.lin_val;
				end
				if (ctl.ld[0]) begin
					lin_a_s1 <= lin_mem[a];
					lin_b_s1 <= lin_mem[b];
				end
			end

			always_ff @(posedge clk) begin
				if (ctl.srgb_we) begin
					srgb_mem[ctl.srgb_idx] <= ctl.srgb_val;
				end
				if (ctl.ld[6]) begin
					srgb_s7 <= srgb_mem[q_s6];
				end
			end

			assign opa = coef.use_linear ? lin_a_s1 : a_s1;
			assign opb = coef.use_linear ? lin_b_s1 : b_s1;
			assign q   = coef.use_linear ? srgb_s7  : q_s7;
		end else begin : g_plain
			assign opa = a_s1;
			assign opb = b_s1;
			assign q   = q_s7;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			ab_s2  <= opa * opb;
			k2a_s2 <= coef.k2 * $signed({1'b0, opa});
			k3b_s2 <= coef.k3 * $signed({1'b0, opb});
		end
		if (ctl.ld[2]) begin
			p1_s3  <= coef.k1 * $signed({1'b0, ab_s2});
			sum_s3 <= k2a_s2 + k3b_s2;
		end
		if (ctl.ld[3]) begin
			t_s4 <= {{(SW-41){p1_s3[40]}}, p1_s3} + coef.k4_term;
			u_s4 <= (sumx <<< 8) - sumx;
		end
		if (ctl.ld[4]) begin
			neg_s5 <= n[SW-1];
			sat_s5 <= n >= SAT_LIM;
			m_s5   <= n[COEF_FRAC_BITS +: 16];
		end
		if (ctl.ld[5]) begin
			if (neg_s5) begin
				q_s6 <= 8'd0;
			end else if (sat_s5) begin
				q_s6 <= 8'd255;
			end else begin
				q_s6 <= prod[30:23];
			end
		end
		if (ctl.ld[6]) begin
			q_s7 <= q_s6;
		end
	end

	assign sumx = {{(SW-34){sum_s3[33]}}, sum_s3};
	assign n    = t_s4 + u_s4;
	assign prod = m_s5 * acp_pkg::RECIP_255;

endmodule

// ===== hdl/arithmetic_composite_pixel.sv =====
// channel  | dir | signals                                            | accepted when
// input    | in  | in_valid/in_ready, req_type, pixel_a, pixel_b,     | in_valid & in_ready
//          |     | table_index, table_value                           |
// output   | out | out_valid/out_ready, pixel_out                     | out_valid & out_ready
// config   | in  | cfg_valid/cfg_ready, cfg_index, cfg_data           | cfg_valid & cfg_ready
//
// One request per cycle while in_ready is high; a pixel pair reaches pixel_out through
// the seven-stage lane pipeline (two multiplier stages, sum, clamp, table read).
// Table writes to the to-sRGB table take effect in stage 7, in request order.
// A stall at the output fills empty stages first; in_ready drops only when all are full.
// arst_n resets valid bits and the config registers; the tables hold no reset.
module arithmetic_composite_pixel #(
	parameter int COEF_FRAC_BITS = acp_pkg::COEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      req_type,
	input  logic [31:0]                     pixel_a,
	input  logic [31:0]                     pixel_b,
	input  logic [7:0]                      table_index,
	input  logic [7:0]                      table_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     pixel_out,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [acp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [acp_pkg::COEF_W-1:0]      cfg_data
);

	localparam int PS = acp_pkg::PIPE_STAGES;

	acp_pkg::coef_t     coef;
	acp_pkg::pipe_ctl_t ctl;

	logic [PS-1:0] v_q;
	logic [PS-1:0] ld;
	logic [1:0]    kind_q [PS-1];
	logic [7:0]    idx_q  [PS-1];
	logic [7:0]    val_q  [PS-1];
	logic [7:0]    lane_q [acp_pkg::LANES];

	acp_cfg #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	assign cfg_ready = 1'b1;

	always_comb begin
		ld[PS-1] = !v_q[PS-1] || out_ready;
		for (int i = PS - 2; i >= 0; i--) begin
			ld[i] = !v_q[i] || ld[i+1];
		end
	end

	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ld[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < PS - 1; i++) begin
				if (ld[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
			if (ld[PS-1]) begin
				v_q[PS-1] <= v_q[PS-2] && (kind_q[PS-2] == acp_pkg::REQ_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			kind_q[0] <= req_type;
			idx_q[0]  <= table_index;
			val_q[0]  <= table_value;
		end
		for (int i = 1; i < PS - 1; i++) begin
			if (ld[i]) begin
				kind_q[i] <= kind_q[i-1];
				idx_q[i]  <= idx_q[i-1];
				val_q[i]  <= val_q[i-1];
			end
		end
	end

	assign ctl.ld       = ld;
	assign ctl.lin_we   = in_valid && ld[0] && (req_type == acp_pkg::REQ_LIN_WR);
	assign ctl.lin_idx  = table_index;
	assign ctl.lin_val  = table_value;
	assign ctl.srgb_we  = ld[PS-1] && v_q[PS-2] && (kind_q[PS-2] == acp_pkg::REQ_SRGB_WR);
	assign ctl.srgb_idx = idx_q[PS-2];
	assign ctl.srgb_val = val_q[PS-2];

	generate
		for (genvar l = 0; l < acp_pkg::LANES; l++) begin : g_lane
			acp_lane #(
				.COEF_FRAC_BITS (COEF_FRAC_BITS),
				.HAS_TABLES     (l < acp_pkg::COLOUR_LANES)
			) u_lane (
				.clk  (clk),
				.ctl  (ctl),
				.coef (coef),
				.a    (pixel_a[8*l +: 8]),
				.b    (pixel_b[8*l +: 8]),
				.q    (lane_q[l])
			);
			assign pixel_out[8*l +: 8] = lane_q[l];
		end
	endgenerate

	assign out_valid = v_q[PS-1];

	ast_blocked_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&v_q))
		else $error("input held off with an empty stage");

	ast_out_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_q[PS-2] && (kind_q[PS-2] == acp_pkg::REQ_PIXEL)))
		else $error("result raised without a pixel request behind it");

	ast_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ld[PS-1] && v_q[PS-2] && (kind_q[PS-2] != acp_pkg::REQ_PIXEL)) |=> !out_valid)
		else $error("table write produced a result");

endmodule

// ===== bench/arithmetic_composite_pixel_tb.sv =====
module arithmetic_composite_pixel_tb;

	localparam int          ONE            = 1 << acp_pkg::COEF_FRAC_BITS;
	localparam logic [23:0] K_MAX          = 24'h7FFFFF;
	localparam logic [23:0] K_MIN          = 24'h800000;
	localparam logic [1:0]  REQ_UNUSED     = 2'd3;
	localparam logic [2:0]  REG_UNUSED     = 3'd7;
	localparam int          WATCHDOG_LIMIT = 3000;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic [1:0]                      req_type    = '0;
	logic [31:0]                     pixel_a     = '0;
	logic [31:0]                     pixel_b     = '0;
	logic [7:0]                      table_index = '0;
	logic [7:0]                      table_value = '0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [31:0]                     pixel_out;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [acp_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [acp_pkg::COEF_W-1:0]      cfg_data    = '0;

	longint      coef_prod   = 0;
	longint      coef_a      = 0;
	longint      coef_b      = 0;
	longint      coef_offset = 0;
	logic        linear_mode = 1'b0;
	logic [7:0]  to_linear_map [256];
	logic [7:0]  to_srgb_map [256];
	logic [31:0] expected_pixels [$];
	int          fault_count  = 0;
	int          burst_left   = 0;
	int          sink_left    = 0;
	int          sink_mode    = 0;
	int          quiet_cycles = 0;

	arithmetic_composite_pixel DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b);
		longint ia, ib, acc, q;
		ia = a;
		ib = b;
		acc = coef_prod * ia * ib + 255 * (coef_a * ia + coef_b * ib) + 65025 * coef_offset
			+ (longint'(255) << (acp_pkg::COEF_FRAC_BITS - 1));
		if (acc < 0)
			return 8'h00;
		q = acc / (longint'(255) << acp_pkg::COEF_FRAC_BITS);
		return (q > 255) ? 8'hFF : q[7:0];
	endfunction

	function automatic logic [31:0] composite_pixel(logic [31:0] a, logic [31:0] b);
		logic [31:0] res;
		logic [7:0]  ca, cb, r;
		res = '0;
		for (int lane = 0; lane < acp_pkg::LANES; lane++) begin
			ca = a[lane*8 +: 8];
			cb = b[lane*8 +: 8];
			if (lane < acp_pkg::COLOUR_LANES && linear_mode) begin
				r = blend_channel(to_linear_map[ca], to_linear_map[cb]);
				r = to_srgb_map[r];
			end else begin
				r = blend_channel(ca, cb);
			end
			res[lane*8 +: 8] = r;
		end
		return res;
	endfunction

	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		p = $urandom;
		for (int lane = 0; lane < acp_pkg::LANES; lane++) begin
			case ($urandom_range(0, 7))
				0: p[lane*8 +: 8] = 8'h00;
				1: p[lane*8 +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return p;
	endfunction

	function automatic logic [23:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return K_MIN;
			1: return K_MAX;
			2: return '0;
			3: return 24'($urandom);
			default: return 24'($urandom_range(0, 4 * ONE)) - 24'(2 * ONE);
		endcase
	endfunction

	task automatic send_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
			logic [7:0] idx, logic [7:0] val);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid    <= 1'b1;
		req_type    <= kind;
		pixel_a     <= a;
		pixel_b     <= b;
		table_index <= idx;
		table_value <= val;
		do @(posedge clk); while (!in_ready);
		case (kind)
			acp_pkg::REQ_PIXEL:   expected_pixels.push_back(composite_pixel(a, b));
			acp_pkg::REQ_LIN_WR:  to_linear_map[idx] = val;
			acp_pkg::REQ_SRGB_WR: to_srgb_map[idx] = val;
			default: ;
		endcase
	endtask

	task automatic send_pixel(logic [31:0] a, logic [31:0] b);
		send_request(acp_pkg::REQ_PIXEL, a, b, 8'($urandom), 8'($urandom));
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (acp_pkg::PIPE_STAGES + 3) @(posedge clk);
	endtask

	task automatic write_reg(logic [acp_pkg::CFG_INDEX_W-1:0] idx,
			logic [acp_pkg::COEF_W-1:0] data);
		drain_pipeline();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			acp_pkg::REG_K1:         coef_prod   = longint'($signed(data));
			acp_pkg::REG_K2:         coef_a      = longint'($signed(data));
			acp_pkg::REG_K3:         coef_b      = longint'($signed(data));
			acp_pkg::REG_K4:         coef_offset = longint'($signed(data));
			acp_pkg::REG_USE_LINEAR: linear_mode = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_coefs(logic [23:0] k1, logic [23:0] k2, logic [23:0] k3,
			logic [23:0] k4);
		write_reg(acp_pkg::REG_K1, k1);
		write_reg(acp_pkg::REG_K2, k2);
		write_reg(acp_pkg::REG_K3, k3);
		write_reg(acp_pkg::REG_K4, k4);
	endtask

	task automatic test_reset_state();
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(32'h00000000, 32'h00000000);
		send_request(REQ_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF);
		send_pixel(32'hA5C3_0F81, 32'h5A3C_F07E);
	endtask

	task automatic test_unit_coefs();
		set_coefs('0, 24'(ONE), '0, '0);
		send_pixel(32'h12345678, 32'h9ABCDEF0);
		send_pixel(32'hFF00FF00, 32'h00FF00FF);
		set_coefs('0, '0, 24'(ONE), '0);
		send_pixel(32'h12345678, 32'h9ABCDEF0);
		set_coefs(24'(ONE), '0, '0, '0);
		send_pixel(32'hFFFFFFFF, 32'h80FF01FF);
		set_coefs('0, '0, '0, 24'(ONE));
		send_pixel(32'h00000000, 32'hFFFFFFFF);
		set_coefs('0, 24'(ONE), '0, 24'(-ONE));
		send_pixel(32'hFF80FE01, 32'h00000000);
		set_coefs('0, 24'(ONE / 2), '0, '0);
		send_pixel(32'h01030507, 32'h00000000);
		set_coefs(K_MAX, K_MAX, K_MAX, K_MAX);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(32'h00000000, 32'h00000000);
		set_coefs(K_MIN, K_MIN, K_MIN, K_MIN);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		set_coefs(K_MAX, K_MIN, K_MAX, K_MIN);
		send_pixel(32'hFF00FF01, 32'h01FFFF00);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		write_reg(acp_pkg::REG_USE_LINEAR, 24'hFFFFFE);
		set_coefs('0, 24'(ONE), 24'(ONE / 3), 24'(-ONE / 7));
		send_pixel(32'h80402010, 32'h7F3F1F0F);
	endtask

	task automatic test_table_load();
		for (int i = 0; i < 256; i++)
			send_request(acp_pkg::REQ_LIN_WR, $urandom, $urandom, 8'(i), 8'($urandom));
		for (int i = 0; i < 256; i++)
			send_request(acp_pkg::REQ_SRGB_WR, $urandom, $urandom, 8'(i), 8'($urandom));
	endtask

	task automatic test_linear_mode();
		logic [7:0] lin_val;
		set_coefs('0, 24'(ONE), '0, '0);
		write_reg(acp_pkg::REG_USE_LINEAR, 24'd1);
		send_pixel(32'hFFFFFFFF, 32'h00000000);
		send_pixel(32'h00000000, 32'hFFFFFFFF);
		lin_val = 8'($urandom);
		send_request(acp_pkg::REQ_LIN_WR, '0, '0, 8'h5A, lin_val);
		send_pixel(32'h805A5A5A, 32'h11223344);
		send_request(acp_pkg::REQ_SRGB_WR, '0, '0, lin_val, 8'($urandom));
		send_pixel(32'h5A5A5A5A, 32'h00000000);
		set_coefs(24'(ONE), 24'(ONE / 2), 24'(-ONE / 4), 24'(ONE / 8));
		send_pixel(random_pixel(), random_pixel());
	endtask

	task automatic test_random_traffic();
		int pick;
		for (int phase = 0; phase < 12; phase++) begin
			set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
			write_reg(acp_pkg::REG_USE_LINEAR, (phase < 2) ? 24'(phase) : 24'($urandom));
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(5, 7)), 24'($urandom));
			for (int n = 0; n < 85; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					send_pixel(random_pixel(), random_pixel());
				else if (pick < 88)
					send_request(acp_pkg::REQ_LIN_WR, $urandom, $urandom, 8'($urandom),
						8'($urandom));
				else if (pick < 96)
					send_request(acp_pkg::REQ_SRGB_WR, $urandom, $urandom, 8'($urandom),
						8'($urandom));
				else
					send_request(REQ_UNUSED, $urandom, $urandom, 8'($urandom), 8'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = $urandom_range(0, 3);
			sink_left = $urandom_range(16, 96);
		end
		sink_left--;
		case (sink_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((sink_left % 24) < 4);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: pixel_out expected none, actual %08h", $time, pixel_out);
				fault_count++;
			end else begin
				logic [31:0] want;
				want = expected_pixels.pop_front();
				if (pixel_out !== want) begin
					$display("%0t: pixel_out expected %08h, actual %08h", $time, want, pixel_out);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_unit_coefs();
		test_table_load();
		test_linear_mode();
		test_random_traffic();
		drain_pipeline();
		repeat (2 * acp_pkg::PIPE_STAGES) @(posedge clk);
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
